[rtl/core/rpi_pkg.sv]
`timescale 1ns / 1ps
package rpi_pkg;

    // Fixed widths of the datapath (inputs are 32-bit signed)
    localparam int W_DATA  = 32;
    localparam int W_THR   = 31;
    localparam int W_PROD  = 64;
    localparam int W_DEN   = 66;
    localparam int W_NUM   = 67;
    localparam int CHUNK   = 23;
    localparam int W_PP    = W_DATA + CHUNK;
    localparam int W_NPROD = W_DATA + W_NUM;
    localparam int Q_BITS  = 41;
    localparam int W_REM   = W_DEN + Q_BITS;
    localparam int W_SUM   = Q_BITS + 2;

    // Quotient magnitude limit, 2^40
    localparam logic [Q_BITS-1:0] QCLAMP = {1'b1, {(Q_BITS-1){1'b0}}};

    localparam logic [W_THR-1:0] THR_RESET = 31'd328;

    // Pipeline depth
    localparam int FRONT_LAT = 3;
    localparam int AXIS_LAT  = Q_BITS + 4;
    localparam int TOTAL_LAT = FRONT_LAT + AXIS_LAT;

endpackage

[rtl/core/rpi_axis.sv]
`timescale 1ns / 1ps
module rpi_axis import rpi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [W_DATA-1:0] i_org,
    input  logic [W_DATA-1:0]        i_dir_mag,
    input  logic                     i_neg,
    input  logic [W_NUM-1:0]         i_num_mag,
    input  logic [W_DEN-1:0]         i_den_mag,
    output logic signed [W_DATA-1:0] o_coord
);

    logic [W_PP-1:0]          r_pp0, r_pp1, r_pp2;
    logic signed [W_DATA-1:0] r_a1_org, r_a2_org;
    logic                     r_a1_neg, r_a2_neg;
    logic [W_DEN-1:0]         r_a1_dm, r_a2_dm;
    logic [W_NPROD-1:0]       r_nprod;

    logic [W_REM-1:0]         r_rem [0:Q_BITS];
    logic [Q_BITS-1:0]        r_q   [0:Q_BITS];
    logic [W_DEN-1:0]         r_dm  [0:Q_BITS];
    logic signed [W_DATA-1:0] r_org [0:Q_BITS];
    logic                     r_neg [0:Q_BITS];
    logic                     r_ovf [0:Q_BITS];

    logic signed [W_DATA-1:0] r_coord;
    logic [Q_BITS-1:0]        n_qm;
    logic signed [W_SUM-1:0]  n_sum;
    logic signed [W_DATA-1:0] n_coord;

    // Partial products of |dir| * |num|
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp0    <= W_PP'(i_dir_mag) * W_PP'(i_num_mag[CHUNK-1:0]);
            r_pp1    <= W_PP'(i_dir_mag) * W_PP'(i_num_mag[2*CHUNK-1:CHUNK]);
            r_pp2    <= W_PP'(i_dir_mag) * W_PP'(i_num_mag[W_NUM-1:2*CHUNK]);
            r_a1_org <= i_org;
            r_a1_neg <= i_neg;
            r_a1_dm  <= i_den_mag;
        end
    end

    // Combine partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nprod  <= W_NPROD'(r_pp0) + (W_NPROD'(r_pp1) << CHUNK)
                      + (W_NPROD'(r_pp2) << (2 * CHUNK));
            r_a2_org <= r_a1_org;
            r_a2_neg <= r_a1_neg;
            r_a2_dm  <= r_a1_dm;
        end
    end

    // Flag quotients beyond the quotient width, then restoring divide one bit per stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= W_REM'(r_nprod);
            r_q[0]   <= '0;
            r_ovf[0] <= W_REM'(r_nprod) >= (W_REM'(r_a2_dm) << Q_BITS);
            r_dm[0]  <= r_a2_dm;
            r_org[0] <= r_a2_org;
            r_neg[0] <= r_a2_neg;
            for (int k = 1; k <= Q_BITS; k++) begin
                if (r_rem[k-1] >= (W_REM'(r_dm[k-1]) << (Q_BITS - k))) begin
                    r_rem[k] <= r_rem[k-1] - (W_REM'(r_dm[k-1]) << (Q_BITS - k));
                    r_q[k]   <= r_q[k-1] | (Q_BITS'(1) << (Q_BITS - k));
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_q[k]   <= r_q[k-1];
                end
                r_ovf[k] <= r_ovf[k-1];
                r_dm[k]  <= r_dm[k-1];
                r_org[k] <= r_org[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    // Clamp quotient, apply sign, add origin, saturate
    always_comb begin
        n_qm = (r_ovf[Q_BITS] || (r_q[Q_BITS] > QCLAMP)) ? QCLAMP : r_q[Q_BITS];
        n_sum = W_SUM'(r_org[Q_BITS]) +
                (r_neg[Q_BITS] ? -$signed({2'b00, n_qm}) : $signed({2'b00, n_qm}));
        if (n_sum > W_SUM'(32'sh7FFF_FFFF)) begin
            n_coord = 32'sh7FFF_FFFF;
        end else if (n_sum < W_SUM'(-33'sh8000_0000)) begin
            n_coord = -32'sh8000_0000;
        end else begin
            n_coord = n_sum[W_DATA-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

[rtl/core/ray_plane_intersection.sv]
`timescale 1ns / 1ps
// Ray / plane intersection, fixed point.
// Input stream: one word per ray, tdata holds ray_org_x/y/z, ray_dir_x/y/z,
// plane_nx/ny/nz, plane_offset, 32 bits each, first in the lowest bits.
// Output stream: tdata holds hit_x/y/z (zero on a miss), tuser holds hit.
// Config channel: i_cfg_data writes parallel_threshold, always ready;
// write it only while no ray is in flight.
// Throughput: one ray per cycle while the receiver does not stall the output.
// The depth is set by the 41-stage restoring divider, one quotient bit per
// stage, after three front stages of products, sums and magnitudes and
// three stages of wide multiply and range check, plus one final stage that
// adds the origin and saturates.
// Reset clears all valid bits and loads the threshold with 328 (0.005).
// When the receiver stalls a full output, the whole pipeline holds and
// o_s_tready drops in the same cycle; no word is lost or repeated.
module ray_plane_intersection import rpi_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // org_x, org_y, org_z, dir_x, dir_y, dir_z, nx, ny, nz, offset
    input  logic [319:0]     i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // hit_x, hit_y, hit_z
    output logic [95:0]      o_m_tdata,
    // hit
    output logic             o_m_tuser,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [W_THR-1:0] i_cfg_data
);

    localparam int W_DSH = W_DATA + FRAC_BITS;

    logic                      en;
    logic                      n_miss;
    logic [W_THR-1:0]          r_thr;
    logic [TOTAL_LAT-1:0]      r_vld;
    logic [AXIS_LAT-1:0]       r_miss;

    logic signed [W_DATA-1:0]  w_org [0:2];
    logic signed [W_DATA-1:0]  w_dir [0:2];
    logic signed [W_DATA-1:0]  w_nrm [0:2];

    logic signed [W_PROD-1:0]  r_p_nv [0:2];
    logic signed [W_PROD-1:0]  r_p_no [0:2];
    logic signed [W_DSH-1:0]   r_dsh;
    logic signed [W_DATA-1:0]  r_o1 [0:2];
    logic signed [W_DATA-1:0]  r_v1 [0:2];

    logic signed [W_DEN-1:0]   r_den;
    logic signed [W_NUM-1:0]   r_num;
    logic signed [W_DATA-1:0]  r_o2 [0:2];
    logic signed [W_DATA-1:0]  r_v2 [0:2];

    logic [W_DEN-1:0]          r_dm;
    logic [W_NUM-1:0]          r_nm;
    logic                      r_neg [0:2];
    logic [W_DATA-1:0]         r_vm [0:2];
    logic signed [W_DATA-1:0]  r_o3 [0:2];

    logic signed [W_DATA-1:0]  w_coord [0:2];

    // Advance unless a finished word is held by the receiver
    assign en          = !r_vld[TOTAL_LAT-1] || i_m_tready;
    assign o_s_tready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_s_tvalid};
        end
    end

    // Unpack the input word
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_org[a] = i_s_tdata[a*W_DATA +: W_DATA];
            w_dir[a] = i_s_tdata[(3+a)*W_DATA +: W_DATA];
            w_nrm[a] = i_s_tdata[(6+a)*W_DATA +: W_DATA];
        end
    end

    // Stage 1: products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_p_nv[a] <= W_PROD'(w_nrm[a]) * W_PROD'(w_dir[a]);
                r_p_no[a] <= W_PROD'(w_nrm[a]) * W_PROD'(w_org[a]);
                r_o1[a]   <= w_org[a];
                r_v1[a]   <= w_dir[a];
            end
            r_dsh <= {i_s_tdata[9*W_DATA +: W_DATA], {FRAC_BITS{1'b0}}};
        end
    end

    // Stage 2: denominator and numerator
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= W_DEN'(r_p_nv[0]) + W_DEN'(r_p_nv[1]) + W_DEN'(r_p_nv[2]);
            r_num <= -W_NUM'(r_dsh) - W_NUM'(r_p_no[0]) - W_NUM'(r_p_no[1])
                   - W_NUM'(r_p_no[2]);
            for (int a = 0; a < 3; a++) begin
                r_o2[a] <= r_o1[a];
                r_v2[a] <= r_v1[a];
            end
        end
    end

    // Stage 3: magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dm <= r_den[W_DEN-1] ? W_DEN'(-r_den) : W_DEN'(r_den);
            r_nm <= r_num[W_NUM-1] ? W_NUM'(-r_num) : W_NUM'(r_num);
            for (int a = 0; a < 3; a++) begin
                r_vm[a]  <= r_v2[a][W_DATA-1] ? W_DATA'(-r_v2[a]) : W_DATA'(r_v2[a]);
                r_neg[a] <= r_v2[a][W_DATA-1] ^ r_num[W_NUM-1] ^ r_den[W_DEN-1];
                r_o3[a]  <= r_o2[a];
            end
        end
    end

    // Parallel check, carried down to the output
    assign n_miss = (r_dm == '0) || (r_dm < (W_DEN'(r_thr) << FRAC_BITS));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_miss <= {r_miss[AXIS_LAT-2:0], n_miss};
        end
    end

    // Per-axis multiply, divide and add
    for (genvar a = 0; a < 3; a++) begin : g_axis
        rpi_axis u_axis (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_org     (r_o3[a]),
            .i_dir_mag (r_vm[a]),
            .i_neg     (r_neg[a]),
            .i_num_mag (r_nm),
            .i_den_mag (r_dm),
            .o_coord   (w_coord[a])
        );
    end

    // Zero the point on a miss
    assign o_m_tvalid = r_vld[TOTAL_LAT-1];
    assign o_m_tuser  = !r_miss[AXIS_LAT-1];
    assign o_m_tdata  = {w_coord[2], w_coord[1], w_coord[0]}
                      & {96{!r_miss[AXIS_LAT-1]}};

endmodule
